FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle
`define ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

FILE: hdl/stsr_pkg.sv
// types and constants for the scsi target select/reselect unit
// no dependencies
package stsr_pkg;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ARB      = 4'd1,
      PH_CHECK    = 4'd2,
      PH_SELDLY   = 4'd3,
      PH_HOLD     = 4'd4,
      PH_RELEASE  = 4'd5,
      PH_POLL     = 4'd6,
      PH_HANDOVER = 4'd7,
      PH_LOST     = 4'd8,
      PH_ABORT    = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      REG_OWN_ID     = 3'd0,
      REG_INIT_ID    = 3'd1,
      REG_ARB_TICKS  = 3'd2,
      REG_SEL_TICKS  = 3'd3,
      REG_SETTLE     = 3'd4,
      REG_POLL_LIMIT = 3'd5,
      REG_RETRY      = 3'd6
   } reg_index_type;

   localparam int unsigned AddrWidth = 5;

   localparam logic [7:0]  RstOwnId     = 8'd1;
   localparam logic [7:0]  RstInitId    = 8'd128;
   localparam logic [15:0] RstArbTicks  = 16'd173;
   localparam logic [15:0] RstSelTicks  = 16'd86;
   localparam logic [7:0]  RstSettle    = 8'd1;
   localparam logic [7:0]  RstPollLimit = 8'd250;
   localparam logic [15:0] RstRetry     = 16'd1000;

   typedef struct packed {
      logic [7:0]  own_id_mask;
      logic [7:0]  initiator_id_mask;
      logic [15:0] arbitration_ticks;
      logic [15:0] select_delay_ticks;
      logic [7:0]  settle_ticks;
      logic [7:0]  busy_poll_limit;
      logic [15:0] retry_interval_ticks;
   } cfg_type;

   typedef struct packed {
      logic       bsy_in;
      logic       sel_in;
      logic       rst_in;
      logic [7:0] data_lines;
      logic       packet_pending;
      logic       clear_flags;
   } req_item_type;

   typedef struct packed {
      logic       bsy_drive;
      logic       sel_drive;
      logic       io_drive;
      logic [7:0] data_drive;
      logic       parity_drive;
      logic       is_selected;
      logic       is_reselected;
      phase_type  phase;
   } rsp_item_type;

endpackage

FILE: hdl/scsi_target_select_reselect_unit.sv
// a transaction waits in the input register, then passes into the sequencer registers
// throughput: one transaction per cycle unless stalled; the input register and the
// sequencer registers (which double as the result register) are one pass of logic apart
// reset: synchronous, active high; phase idle, all lines released, counters and
// flags zero, configuration registers at their defaults
// top level of the scsi target select/reselect unit; uses stsr_pkg, stsr_csr, stsr_seq
module scsi_target_select_reselect_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_bsy_in,
   input  logic                           req_sel_in,
   input  logic                           req_rst_in,
   input  logic [7:0]                     req_data_lines,
   input  logic                           req_packet_pending,
   input  logic                           req_clear_flags,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_bsy_drive,
   output logic                           rsp_sel_drive,
   output logic                           rsp_io_drive,
   output logic [7:0]                     rsp_data_drive,
   output logic                           rsp_parity_drive,
   output logic                           rsp_is_selected,
   output logic                           rsp_is_reselected,
   output logic [3:0]                     rsp_phase,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [stsr_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   stsr_pkg::cfg_type      cfg;
   stsr_pkg::req_item_type in_ff, in_in;
   stsr_pkg::rsp_item_type result;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   advance;
   logic                   take;

   stsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      in_in = in_ff;
      if (take) begin
         in_in.bsy_in         = req_bsy_in;
         in_in.sel_in         = req_sel_in;
         in_in.rst_in         = req_rst_in;
         in_in.data_lines     = req_data_lines;
         in_in.packet_pending = req_packet_pending;
         in_in.clear_flags    = req_clear_flags;
      end
      in_valid_in  = take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   stsr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_bsy_drive     = result.bsy_drive;
   assign rsp_sel_drive     = result.sel_drive;
   assign rsp_io_drive      = result.io_drive;
   assign rsp_data_drive    = result.data_drive;
   assign rsp_parity_drive  = result.parity_drive;
   assign rsp_is_selected   = result.is_selected;
   assign rsp_is_reselected = result.is_reselected;
   assign rsp_phase         = result.phase;

endmodule

FILE: hdl/stsr_csr.sv
// apb-style configuration registers of the select/reselect unit
// depends on stsr_pkg
module stsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stsr_pkg::AddrWidth-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output stsr_pkg::cfg_type                   cfg
);

   stsr_pkg::cfg_type       cfg_ff, cfg_in;
   stsr_pkg::reg_index_type index;
   logic                    write_en;

   assign pready   = 1'b1;
   assign index    = stsr_pkg::reg_index_type'(paddr[stsr_pkg::AddrWidth-1:2]);
   assign write_en = psel & penable & pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            stsr_pkg::REG_OWN_ID:     cfg_in.own_id_mask          = pwdata[7:0];
            stsr_pkg::REG_INIT_ID:    cfg_in.initiator_id_mask    = pwdata[7:0];
            stsr_pkg::REG_ARB_TICKS:  cfg_in.arbitration_ticks    = pwdata[15:0];
            stsr_pkg::REG_SEL_TICKS:  cfg_in.select_delay_ticks   = pwdata[15:0];
            stsr_pkg::REG_SETTLE:     cfg_in.settle_ticks         = pwdata[7:0];
            stsr_pkg::REG_POLL_LIMIT: cfg_in.busy_poll_limit      = pwdata[7:0];
            stsr_pkg::REG_RETRY:      cfg_in.retry_interval_ticks = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         stsr_pkg::REG_OWN_ID:     prdata = {24'd0, cfg_ff.own_id_mask};
         stsr_pkg::REG_INIT_ID:    prdata = {24'd0, cfg_ff.initiator_id_mask};
         stsr_pkg::REG_ARB_TICKS:  prdata = {16'd0, cfg_ff.arbitration_ticks};
         stsr_pkg::REG_SEL_TICKS:  prdata = {16'd0, cfg_ff.select_delay_ticks};
         stsr_pkg::REG_SETTLE:     prdata = {24'd0, cfg_ff.settle_ticks};
         stsr_pkg::REG_POLL_LIMIT: prdata = {24'd0, cfg_ff.busy_poll_limit};
         stsr_pkg::REG_RETRY:      prdata = {16'd0, cfg_ff.retry_interval_ticks};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id_mask          <= stsr_pkg::RstOwnId;
         cfg_ff.initiator_id_mask    <= stsr_pkg::RstInitId;
         cfg_ff.arbitration_ticks    <= stsr_pkg::RstArbTicks;
         cfg_ff.select_delay_ticks   <= stsr_pkg::RstSelTicks;
         cfg_ff.settle_ticks         <= stsr_pkg::RstSettle;
         cfg_ff.busy_poll_limit      <= stsr_pkg::RstPollLimit;
         cfg_ff.retry_interval_ticks <= stsr_pkg::RstRetry;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/stsr_seq.sv
// selection response and reselection sequencer, one bus tick per step
// depends on stsr_pkg
module stsr_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  stsr_pkg::req_item_type item,
   input  stsr_pkg::cfg_type      cfg,
   output stsr_pkg::rsp_item_type result
);

   stsr_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         tick_ff, tick_in;
   logic [7:0]          poll_ff, poll_in;
   logic [15:0]         retry_ff, retry_in;
   logic                armed_ff, armed_in;
   logic                selflag_ff, selflag_in;
   logic                resel_ff, resel_in;
   logic                bsy_ff, bsy_in;
   logic                sel_ff, sel_in;
   logic                io_ff, io_in;
   logic [7:0]          data_ff, data_in;
   logic                par_ff, par_in;

   logic [15:0] tick_inc;
   logic [15:0] retry_inc;
   logic [7:0]  poll_inc;
   logic [15:0] settle_x1, settle_x3, settle_x4, settle_x5;
   logic [7:0]  higher_ids;
   logic        lost_arb;
   logic        busy_seq;
   logic        sel_seen;
   logic        arm_req;
   logic        armed_now;
   logic        retry_fire;

   assign tick_inc  = tick_ff + 16'd1;
   assign retry_inc = retry_ff + 16'd1;
   assign poll_inc  = poll_ff + 8'd1;
   assign settle_x1 = {8'd0, cfg.settle_ticks};
   assign settle_x4 = {6'd0, cfg.settle_ticks, 2'b00};
   assign settle_x3 = settle_x4 - settle_x1;
   assign settle_x5 = settle_x4 + settle_x1;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         higher_ids[i] = ({1'b0, cfg.own_id_mask} < (9'd1 << i));
      end
   end

   assign lost_arb = |(~item.data_lines & higher_ids);
   assign busy_seq = (phase_ff == stsr_pkg::PH_ARB) || (phase_ff == stsr_pkg::PH_CHECK) ||
                     (phase_ff == stsr_pkg::PH_SELDLY) || (phase_ff == stsr_pkg::PH_HOLD) ||
                     (phase_ff == stsr_pkg::PH_RELEASE) || (phase_ff == stsr_pkg::PH_POLL) ||
                     (phase_ff == stsr_pkg::PH_HANDOVER);
   assign sel_seen   = item.sel_in & ~item.rst_in;
   assign arm_req    = ~item.sel_in & item.packet_pending & ~(resel_ff & ~item.clear_flags);
   assign armed_now  = armed_ff | arm_req;
   assign retry_fire = ~item.bsy_in & ~sel_seen & armed_now &
                       (retry_inc >= cfg.retry_interval_ticks);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         stsr_pkg::PH_ARB: begin
            if ((tick_inc >= cfg.arbitration_ticks) || item.sel_in) begin
               phase_in = stsr_pkg::PH_CHECK;
            end
         end
         stsr_pkg::PH_CHECK: begin
            phase_in = lost_arb ? stsr_pkg::PH_LOST : stsr_pkg::PH_SELDLY;
         end
         stsr_pkg::PH_SELDLY: begin
            if (tick_inc >= cfg.select_delay_ticks) phase_in = stsr_pkg::PH_HOLD;
         end
         stsr_pkg::PH_HOLD: begin
            if (tick_inc >= settle_x5) phase_in = stsr_pkg::PH_RELEASE;
         end
         stsr_pkg::PH_RELEASE: begin
            if (tick_inc >= settle_x1) phase_in = stsr_pkg::PH_POLL;
         end
         stsr_pkg::PH_POLL: begin
            if (item.bsy_in) begin
               phase_in = stsr_pkg::PH_HANDOVER;
            end else if (poll_inc >= cfg.busy_poll_limit) begin
               phase_in = stsr_pkg::PH_ABORT;
            end
         end
         stsr_pkg::PH_HANDOVER: begin
            if (tick_inc >= settle_x4) phase_in = stsr_pkg::PH_IDLE;
         end
         default: begin
            phase_in = retry_fire ? stsr_pkg::PH_ARB : stsr_pkg::PH_IDLE;
         end
      endcase
   end

   // counters, flags and line drives
   always_comb begin
      tick_in    = tick_ff;
      poll_in    = poll_ff;
      retry_in   = retry_ff;
      armed_in   = armed_ff;
      selflag_in = selflag_ff;
      resel_in   = resel_ff;
      bsy_in     = bsy_ff;
      sel_in     = sel_ff;
      io_in      = io_ff;
      data_in    = data_ff;
      par_in     = par_ff;

      if (item.clear_flags) begin
         selflag_in = 1'b0;
         resel_in   = 1'b0;
         if (!busy_seq) begin
            bsy_in  = 1'b0;
            sel_in  = 1'b0;
            io_in   = 1'b0;
            data_in = 8'd0;
            par_in  = 1'b0;
         end
      end

      if ((phase_ff != stsr_pkg::PH_LOST) && (phase_ff != stsr_pkg::PH_ABORT)) begin
         tick_in = tick_inc;
      end

      case (phase_ff)
         stsr_pkg::PH_ARB: ;
         stsr_pkg::PH_CHECK: begin
            if (lost_arb) begin
               bsy_in  = 1'b0;
               sel_in  = 1'b0;
               io_in   = 1'b0;
               data_in = 8'd0;
               par_in  = 1'b0;
            end else begin
               sel_in  = 1'b1;
               tick_in = 16'd0;
            end
         end
         stsr_pkg::PH_SELDLY: begin
            if (tick_inc >= cfg.select_delay_ticks) begin
               data_in = data_in | cfg.initiator_id_mask;
               par_in  = ~^(cfg.own_id_mask | cfg.initiator_id_mask);
               io_in   = 1'b1;
               tick_in = 16'd0;
            end
         end
         stsr_pkg::PH_HOLD: begin
            if (tick_inc >= settle_x5) begin
               bsy_in  = 1'b0;
               tick_in = 16'd0;
            end
         end
         stsr_pkg::PH_RELEASE: begin
            if (tick_inc >= settle_x1) poll_in = 8'd0;
         end
         stsr_pkg::PH_POLL: begin
            if (item.bsy_in) begin
               tick_in = 16'd0;
            end else begin
               poll_in = poll_inc;
               if (poll_inc >= cfg.busy_poll_limit) begin
                  bsy_in  = 1'b0;
                  sel_in  = 1'b0;
                  io_in   = 1'b0;
                  data_in = 8'd0;
                  par_in  = 1'b0;
               end
            end
         end
         stsr_pkg::PH_HANDOVER: begin
            if (tick_inc >= settle_x1) bsy_in = 1'b1;
            if (tick_inc >= settle_x3) sel_in = 1'b0;
            if (tick_inc >= settle_x4) begin
               data_in  = 8'd0;
               par_in   = 1'b0;
               io_in    = 1'b0;
               resel_in = 1'b1;
               armed_in = 1'b0;
               retry_in = 16'd0;
            end
         end
         default: begin
            if (item.bsy_in) begin
               armed_in = 1'b0;
               retry_in = 16'd0;
            end else if (sel_seen) begin
               if ((~item.data_lines & cfg.own_id_mask) == cfg.own_id_mask) begin
                  bsy_in     = 1'b1;
                  selflag_in = 1'b1;
               end
            end else begin
               armed_in = armed_now;
               if (armed_now) begin
                  retry_in = retry_inc;
                  if (retry_fire) begin
                     retry_in = 16'd0;
                     bsy_in   = 1'b1;
                     data_in  = cfg.own_id_mask;
                     par_in   = 1'b0;
                     tick_in  = 16'd0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= stsr_pkg::PH_IDLE;
         tick_ff    <= 16'd0;
         poll_ff    <= 8'd0;
         retry_ff   <= 16'd0;
         armed_ff   <= 1'b0;
         selflag_ff <= 1'b0;
         resel_ff   <= 1'b0;
         bsy_ff     <= 1'b0;
         sel_ff     <= 1'b0;
         io_ff      <= 1'b0;
         data_ff    <= 8'd0;
         par_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         poll_ff    <= poll_in;
         retry_ff   <= retry_in;
         armed_ff   <= armed_in;
         selflag_ff <= selflag_in;
         resel_ff   <= resel_in;
         bsy_ff     <= bsy_in;
         sel_ff     <= sel_in;
         io_ff      <= io_in;
         data_ff    <= data_in;
         par_ff     <= par_in;
      end
   end

   assign result.bsy_drive     = bsy_ff;
   assign result.sel_drive     = sel_ff;
   assign result.io_drive      = io_ff;
   assign result.data_drive    = data_ff;
   assign result.parity_drive  = par_ff;
   assign result.is_selected   = selflag_ff;
   assign result.is_reselected = resel_ff;
   assign result.phase         = phase_ff;

endmodule

FILE: hdl/stsr_checker.sv
// port-level checks of the scsi target select/reselect unit, bound to the top level
// depends on stsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module stsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_bsy_drive,
   input logic       rsp_sel_drive,
   input logic       rsp_io_drive,
   input logic [7:0] rsp_data_drive,
   input logic       rsp_parity_drive,
   input logic [3:0] rsp_phase
);

   logic lines_free;
   logic in_lost;
   logic in_hold;

   assign lines_free = ~rsp_bsy_drive & ~rsp_sel_drive & ~rsp_io_drive &
                       (rsp_data_drive == 8'd0) & ~rsp_parity_drive;
   assign in_lost    = (rsp_phase == 4'(stsr_pkg::PH_LOST)) ||
                       (rsp_phase == 4'(stsr_pkg::PH_ABORT));
   assign in_hold    = (rsp_phase == 4'(stsr_pkg::PH_HOLD));

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // with no result waiting the input side never stalls
   `ASSERT_SAME(a_no_stall, clock, reset, !rsp_valid, !req_stall)
   // lost arbitration and abort leave the bus released
   `ASSERT_SAME(a_lost_free, clock, reset, rsp_valid && in_lost, lines_free)
   // while holding, sel and io are both driven
   `ASSERT_SAME(a_hold_lines, clock, reset, rsp_valid && in_hold,
      rsp_sel_drive && rsp_io_drive)

endmodule

bind scsi_target_select_reselect_unit stsr_checker u_stsr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bsy_drive    (rsp_bsy_drive),
   .rsp_sel_drive    (rsp_sel_drive),
   .rsp_io_drive     (rsp_io_drive),
   .rsp_data_drive   (rsp_data_drive),
   .rsp_parity_drive (rsp_parity_drive),
   .rsp_phase        (rsp_phase)
);
